/* sv/itp_pkg.sv */
// Shared constants and helper functions for the infix-to-postfix converter.
// No dependencies; used by every module of the block.
`default_nettype none
package itp_pkg;

    localparam int unsigned CHAR_W      = 8;
    localparam int unsigned MAX_RESULTS = 32;
    localparam int unsigned RUN_W       = $clog2(MAX_RESULTS + 1);

    localparam logic [CHAR_W-1:0] CHR_LPAREN = 8'h28;
    localparam logic [CHAR_W-1:0] CHR_RPAREN = 8'h29;
    localparam logic [CHAR_W-1:0] CHR_CARET  = 8'h5E;
    localparam logic [CHAR_W-1:0] CHR_PLUS   = 8'h2B;
    localparam logic [CHAR_W-1:0] CHR_MINUS  = 8'h2D;
    localparam logic [CHAR_W-1:0] CHR_STAR   = 8'h2A;
    localparam logic [CHAR_W-1:0] CHR_SLASH  = 8'h2F;
    localparam logic [CHAR_W-1:0] CHR_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CHR_TAB    = 8'h09;

    localparam logic [1:0] RANK_NONE = 2'd0;
    localparam logic [1:0] RANK_ADD  = 2'd1;
    localparam logic [1:0] RANK_MUL  = 2'd2;
    localparam logic [1:0] RANK_POW  = 2'd3;

    // Unknown characters rank lowest, which keeps the ordering of the precedences.
    function automatic logic [1:0] prec_rank(input logic [CHAR_W-1:0] c);
        logic [1:0] r;
        case (c)
            CHR_PLUS, CHR_MINUS: r = RANK_ADD;
            CHR_STAR, CHR_SLASH: r = RANK_MUL;
            CHR_CARET:           r = RANK_POW;
            default:             r = RANK_NONE;
        endcase
        return r;
    endfunction

    function automatic logic is_operand(input logic [CHAR_W-1:0] c);
        return (c inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39]});
    endfunction

endpackage
`default_nettype wire

/* sv/itp_stack_ram.sv */
// Operator stack storage: one write port and one registered read port.
// Depends on itp_pkg for the character width.
`default_nettype none
module itp_stack_ram #(
    parameter int unsigned DEPTH = 32,
    parameter int unsigned AW    = 5
) (
    input  wire                          i_clk,
    input  wire                          i_wr_en,
    input  wire  [AW-1:0]                i_wr_addr,
    input  wire  [itp_pkg::CHAR_W-1:0]   i_wr_data,
    input  wire                          i_rd_en,
    input  wire  [AW-1:0]                i_rd_addr,
    output logic [itp_pkg::CHAR_W-1:0]   o_rd_data
);

    logic [itp_pkg::CHAR_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

/* sv/infix_to_postfix_converter.sv */
// Top level of the shunting-yard infix-to-postfix converter: control and output register.
// Depends on itp_pkg and itp_stack_ram.
//
//   Channel | Signals                                         | Beat
//   in      | i_in_valid, o_in_ready, i_symbol, i_end_mark    | one input character
//   out     | o_out_valid, i_out_ready, o_out_char,           | one postfix result
//           | o_char_valid, o_last_of_run, o_expr_done        |
//
// A space, tab or '(' is handled in the idle state; an operand goes through the emit state.
// An operator or ')' pops entries in the scan state; an end beat pops every stacked entry
// in the flush state, at most 32 emitted. Each pop that leaves entries on the stack issues one
// read of the stack memory, whose data comes back in the next cycle as the new top of stack.
// Reset empties the stack at once. A stalled output holds the beat in the output register.
`default_nettype none
module infix_to_postfix_converter #(
    parameter int unsigned STACK_DEPTH = 32
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    output logic                         o_in_ready,
    input  wire  [itp_pkg::CHAR_W-1:0]   i_symbol,
    input  wire                          i_end_mark,
    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    output logic [itp_pkg::CHAR_W-1:0]   o_out_char,
    output logic                         o_char_valid,
    output logic                         o_last_of_run,
    output logic                         o_expr_done
);

    localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);
    localparam logic [itp_pkg::RUN_W-1:0] RUN_MAX = itp_pkg::RUN_W'(itp_pkg::MAX_RESULTS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EMIT,
        ST_SCAN,
        ST_FLUSH
    } t_state;

    t_state                      r_state, n_state;
    logic [CW-1:0]               r_count, n_count;
    logic [itp_pkg::CHAR_W-1:0]  r_top, n_top;
    logic                        r_from_mem, n_from_mem;
    logic [itp_pkg::CHAR_W-1:0]  r_char, n_char;
    logic [itp_pkg::CHAR_W-1:0]  r_pend, n_pend;
    logic                        r_pend_v, n_pend_v;
    logic [itp_pkg::RUN_W-1:0]   r_run, n_run;
    logic                        r_out_v, n_out_v;
    logic [itp_pkg::CHAR_W-1:0]  r_out_char, n_out_char;
    logic                        r_out_cv, n_out_cv;
    logic                        r_out_last, n_out_last;
    logic                        r_out_done, n_out_done;

    logic                        wr_en, rd_en;
    logic [AW-1:0]               wr_addr, rd_addr;
    logic [itp_pkg::CHAR_W-1:0]  wr_data, rd_data, top_cur;
    logic                        slot_free, accept, is_close, cont, go;
    logic [CW-1:0]               count_m2;

    itp_stack_ram #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_stack (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign top_cur   = r_from_mem ? rd_data : r_top;
    assign slot_free = !r_out_v || i_out_ready;
    assign accept    = i_in_valid && o_in_ready;
    assign is_close  = (r_char == itp_pkg::CHR_RPAREN);
    assign count_m2  = r_count - CW'(2);
    assign o_in_ready = (r_state == ST_IDLE);
    assign go        = !r_pend_v || slot_free;
    assign cont      = (r_count != '0) && (top_cur != itp_pkg::CHR_LPAREN) &&
                       (is_close || (itp_pkg::prec_rank(r_char) <=
                                     itp_pkg::prec_rank(top_cur))) &&
                       (r_run != RUN_MAX);

    assign o_out_valid   = r_out_v;
    assign o_out_char    = r_out_char;
    assign o_char_valid  = r_out_cv;
    assign o_last_of_run = r_out_last;
    assign o_expr_done   = r_out_done;

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_top      = top_cur;
        n_from_mem = 1'b0;
        n_char     = r_char;
        n_pend     = r_pend;
        n_pend_v   = r_pend_v;
        n_run      = r_run;
        n_out_v    = r_out_v && !i_out_ready;
        n_out_char = r_out_char;
        n_out_cv   = r_out_cv;
        n_out_last = r_out_last;
        n_out_done = r_out_done;
        wr_en      = 1'b0;
        wr_addr    = r_count[AW-1:0];
        wr_data    = r_char;
        rd_en      = 1'b0;
        rd_addr    = count_m2[AW-1:0];

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_end_mark) begin
                        n_state  = ST_FLUSH;
                        n_run    = '0;
                        n_pend_v = 1'b0;
                    end else if (i_symbol == itp_pkg::CHR_SPACE ||
                                 i_symbol == itp_pkg::CHR_TAB) begin
                        n_state = ST_IDLE;
                    end else if (itp_pkg::is_operand(i_symbol)) begin
                        n_pend  = i_symbol;
                        n_state = ST_EMIT;
                    end else if (i_symbol == itp_pkg::CHR_LPAREN) begin
                        if (r_count < FULL) begin
                            wr_en   = 1'b1;
                            wr_data = i_symbol;
                            n_top   = i_symbol;
                            n_count = r_count + CW'(1);
                        end
                    end else begin
                        n_char   = i_symbol;
                        n_run    = '0;
                        n_pend_v = 1'b0;
                        n_state  = ST_SCAN;
                    end
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    n_out_v    = 1'b1;
                    n_out_char = r_pend;
                    n_out_cv   = 1'b1;
                    n_out_last = 1'b1;
                    n_out_done = 1'b0;
                    n_state    = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (go) begin
                    if (r_pend_v) begin
                        n_out_v    = 1'b1;
                        n_out_char = r_pend;
                        n_out_cv   = 1'b1;
                        n_out_last = !cont;
                        n_out_done = 1'b0;
                    end
                    if (cont) begin
                        n_pend     = top_cur;
                        n_pend_v   = 1'b1;
                        n_run      = r_run + itp_pkg::RUN_W'(1);
                        n_count    = r_count - CW'(1);
                        rd_en      = (r_count > CW'(1));
                        n_from_mem = rd_en;
                    end else begin
                        n_pend_v = 1'b0;
                        n_state  = ST_IDLE;
                        if (is_close) begin
                            if (r_count != '0 && top_cur == itp_pkg::CHR_LPAREN) begin
                                n_count    = r_count - CW'(1);
                                rd_en      = (r_count > CW'(1));
                                n_from_mem = rd_en;
                            end
                        end else if (r_count < FULL) begin
                            wr_en   = 1'b1;
                            n_top   = r_char;
                            n_count = r_count + CW'(1);
                        end
                    end
                end
            end
            ST_FLUSH: begin
                if (r_count == '0 || r_run == RUN_MAX) begin
                    if (slot_free) begin
                        n_out_v    = 1'b1;
                        n_out_char = r_pend_v ? r_pend : '0;
                        n_out_cv   = r_pend_v;
                        n_out_last = 1'b1;
                        n_out_done = 1'b1;
                        n_pend_v   = 1'b0;
                        n_count    = '0;
                        n_state    = ST_IDLE;
                    end
                end else if (top_cur == itp_pkg::CHR_LPAREN) begin
                    n_count    = r_count - CW'(1);
                    rd_en      = (r_count > CW'(1));
                    n_from_mem = rd_en;
                end else if (go) begin
                    if (r_pend_v) begin
                        n_out_v    = 1'b1;
                        n_out_char = r_pend;
                        n_out_cv   = 1'b1;
                        n_out_last = 1'b0;
                        n_out_done = 1'b0;
                    end
                    n_pend     = top_cur;
                    n_pend_v   = 1'b1;
                    n_run      = r_run + itp_pkg::RUN_W'(1);
                    n_count    = r_count - CW'(1);
                    rd_en      = (r_count > CW'(1));
                    n_from_mem = rd_en;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_count    <= '0;
            r_from_mem <= 1'b0;
            r_pend_v   <= 1'b0;
            r_out_v    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_from_mem <= n_from_mem;
            r_pend_v   <= n_pend_v;
            r_out_v    <= n_out_v;
        end
        r_top      <= n_top;
        r_char     <= n_char;
        r_pend     <= n_pend;
        r_run      <= n_run;
        r_out_char <= n_out_char;
        r_out_cv   <= n_out_cv;
        r_out_last <= n_out_last;
        r_out_done <= n_out_done;
    end

endmodule
`default_nettype wire
